@@ hdl/egp_pkg.sv @@
// ----------------------------------------------------------------------------
// egp_pkg: shared types and constants of the reference index parser
// Word formats for both channels, the parser state record and the codes used
// by the decode logic and the top level.
// ----------------------------------------------------------------------------
package egp_pkg;

    // Largest partition count of a macroblock and number of references.
    localparam int MAX_PARTS = 4;
    localparam int MAX_REFS  = 32;

    // Operation codes of an input word.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BIT   = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_PREFIX = 3'b010,
        PH_SUFFIX = 3'b100
    } egp_phase_t;

    typedef struct packed {
        logic       operation;
        logic [2:0] num_parts;
        logic [3:0] list_use_mask;
        logic [3:0] motion_pred_mask;
        logic       stream_bit;
    } egp_in_t;

    typedef struct packed {
        logic [1:0] part_index;
        logic [4:0] ref_index;
        logic [1:0] status;
        logic       last;
    } egp_out_t;

    typedef struct packed {
        egp_phase_t phase;
        logic [3:0] pending_mask;
        logic [1:0] current_part;
        logic [4:0] zero_count;
        logic [4:0] suffix_left;
        logic [4:0] value_accum;
        logic       value_too_big;
    } egp_state_t;

endpackage

@@ hdl/egp_decode.sv @@
// ----------------------------------------------------------------------------
// egp_decode: next-state and result logic of the parser
// Takes one input word and the current parser state and works out the next
// state and at most one result word.
// ----------------------------------------------------------------------------
module egp_decode (
    input  egp_pkg::egp_in_t    word,
    input  egp_pkg::egp_state_t state,
    input  logic [4:0]          max_ref_index,
    output egp_pkg::egp_state_t state_next,
    output logic                res_valid,
    output egp_pkg::egp_out_t   res_word
);
    import egp_pkg::*;

    localparam logic [4:0] REF_LIMIT = 5'(MAX_REFS - 1);
    localparam logic [2:0] PART_LIMIT = 3'(MAX_PARTS);

    function automatic logic [1:0] lowest_part(input logic [3:0] m);
        logic [1:0] p;
        if (m[0])
            p = 2'd0;
        else if (m[1])
            p = 2'd1;
        else if (m[2])
            p = 2'd2;
        else if (m[3])
            p = 2'd3;
        else
            p = 2'd0;
        return p;
    endfunction

    egp_state_t cleared;
    logic [2:0] parts;
    logic [3:0] need;
    logic [3:0] left_mask;
    logic [4:0] limit;
    logic [6:0] grown;
    logic [4:0] acc_new;
    logic       big_new;
    logic [4:0] sl_new;
    logic       code_end;
    logic       finish;
    logic       fail;
    logic [4:0] finish_idx;

    always_comb
    begin
        cleared = '{phase: PH_IDLE, pending_mask: 4'd0, current_part: 2'd0,
                    zero_count: 5'd0, suffix_left: 5'd0, value_accum: 5'd0,
                    value_too_big: 1'b0};

        parts = (word.num_parts > PART_LIMIT) ? PART_LIMIT : word.num_parts;
        need  = word.list_use_mask & ~word.motion_pred_mask
              & 4'((5'd1 << parts) - 5'd1);
        limit = (max_ref_index > REF_LIMIT) ? REF_LIMIT : max_ref_index;

        // One suffix bit: codeNum grows as 2 * acc + 1 + bit, saturating at 31.
        grown   = 7'({state.value_accum, 1'b0}) + 7'd1 + 7'(word.stream_bit);
        big_new = state.value_too_big | (grown > 7'd31);
        acc_new = (grown > 7'd31) ? 5'd31 : grown[4:0];
        sl_new  = state.suffix_left - 5'd1;

        state_next = state;
        res_valid  = 1'b0;
        res_word   = '{part_index: state.current_part, ref_index: 5'd0,
                       status: ST_RANGE, last: 1'b1};
        finish     = 1'b0;
        fail       = 1'b0;
        finish_idx = 5'd0;
        code_end   = 1'b0;
        left_mask  = state.pending_mask & ~(4'd1 << state.current_part);

        if (word.operation == OP_START)
        begin
            // A new start abandons whatever was in progress.
            if (need == 4'd0)
            begin
                state_next = cleared;
                res_valid  = 1'b1;
                res_word   = '{part_index: 2'd0, ref_index: 5'd0,
                               status: ST_EMPTY, last: 1'b1};
            end
            else
            begin
                state_next = cleared;
                state_next.phase        = PH_PREFIX;
                state_next.pending_mask = need;
                state_next.current_part = lowest_part(need);
            end
        end
        else
        begin
            case (state.phase)
                PH_PREFIX:
                begin
                    if (state.zero_count == 5'd0 && max_ref_index == 5'd0)
                    begin
                        finish     = 1'b1;
                        finish_idx = {4'd0, ~word.stream_bit};
                    end
                    else if (!word.stream_bit)
                    begin
                        if (state.zero_count == 5'd31)
                            fail = 1'b1;
                        else
                            state_next.zero_count = state.zero_count + 5'd1;
                    end
                    else if (state.zero_count == 5'd0)
                    begin
                        // A lone one codes index zero, always in range.
                        finish     = 1'b1;
                        finish_idx = 5'd0;
                    end
                    else
                    begin
                        state_next.phase         = PH_SUFFIX;
                        state_next.suffix_left   = state.zero_count;
                        state_next.value_accum   = 5'd0;
                        state_next.value_too_big = 1'b0;
                    end
                end
                PH_SUFFIX:
                begin
                    state_next.value_accum   = acc_new;
                    state_next.value_too_big = big_new;
                    state_next.suffix_left   = sl_new;
                    if (sl_new == 5'd0)
                    begin
                        code_end = 1'b1;
                        if (big_new || acc_new > limit)
                            fail = 1'b1;
                        else
                        begin
                            finish     = 1'b1;
                            finish_idx = acc_new;
                        end
                    end
                end
                default:
                begin
                    // A stream bit while idle is dropped.
                    state_next = state;
                end
            endcase

            if (fail)
            begin
                state_next = cleared;
                res_valid  = 1'b1;
                res_word   = '{part_index: state.current_part, ref_index: 5'd0,
                               status: ST_RANGE, last: 1'b1};
            end
            else if (finish)
            begin
                res_valid = 1'b1;
                res_word  = '{part_index: state.current_part, ref_index: finish_idx,
                              status: ST_OK, last: (left_mask == 4'd0)};
                if (left_mask == 4'd0)
                    state_next = cleared;
                else
                begin
                    state_next = cleared;
                    state_next.phase        = PH_PREFIX;
                    state_next.pending_mask = left_mask;
                    state_next.current_part = lowest_part(left_mask);
                end
            end
        end

        if (code_end && !finish && !fail)
            state_next.phase = PH_IDLE;
    end

endmodule

@@ hdl/egp_out_buf.sv @@
// ----------------------------------------------------------------------------
// egp_out_buf: two-entry result buffer
// An output register with a skid entry behind it, so that a result produced
// while the consumer stalls is kept and the input side stalls only after.
// ----------------------------------------------------------------------------
module egp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  egp_pkg::egp_out_t push_word,
    output logic              full,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output egp_pkg::egp_out_t rsp_word
);
    import egp_pkg::*;

    logic     main_valid_reg;
    logic     main_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    egp_out_t main_reg;
    egp_out_t main_next;
    egp_out_t skid_reg;
    egp_out_t skid_next;
    logic     pop;

    assign pop = main_valid_reg && !rsp_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = main_valid_reg;
    assign rsp_word  = main_reg;

`ifndef NO_ASSERTIONS
    // The skid entry is only ever filled behind a waiting output word.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without an output word");

    // A word refused by the consumer is still offered in the next cycle.
    a_stalled_kept: assert property (@(posedge clk) disable iff (!rst_n)
        main_valid_reg && rsp_stall |=> main_valid_reg)
        else $error("stalled result word lost");

    // A push is never made while the buffer reports full.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push_valid)
        else $error("result pushed into a full buffer");
`endif

endmodule

@@ hdl/ref_index_exp_golomb_parser.sv @@
// ----------------------------------------------------------------------------
// ref_index_exp_golomb_parser: bit-serial reference index parser
// Decodes the te(v)/ue(v) reference indices of one macroblock, one bitstream
// bit per input word: one result per index, or one empty or out-of-range one.
// ----------------------------------------------------------------------------
// The parser takes one input word per clock cycle while req_stall is low. A
// start word names the partitions of a macroblock and which of them carry a
// coded index; each following word delivers a single bitstream bit. The whole
// decision for a word (prefix counting, suffix accumulation, range check and
// choice of the next partition) is made in the cycle in which the word is
// accepted, and its result word is sent out from a register. Results pass
// through a two-entry buffer: when the consumer stalls, one further result is
// held in the skid entry and req_stall rises only from the following cycle,
// so the sustained rate is one word per cycle whenever the consumer keeps up.
// The register max_ref_index is written through the configuration port,
// which is always ready; it must only be changed while no macroblock is in
// progress and no result is outstanding. A value of zero selects the one-bit
// inverted code, not range checked; else an index above the register value,
// or thirty-two leading zeros, ends the macroblock as out of range.
// ----------------------------------------------------------------------------
module ref_index_exp_golomb_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  egp_pkg::egp_in_t  req_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output egp_pkg::egp_out_t rsp_word,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data
);
    import egp_pkg::*;

    egp_state_t state_reg;
    egp_state_t state_next;
    egp_state_t dec_state;
    logic [4:0] max_ref_reg;
    logic       accept;
    logic       res_valid;
    egp_out_t   res_word;
    logic       buf_full;

    // The stall is taken straight from the skid entry, a register, so it
    // never depends on the producer's valid.
    assign req_stall = buf_full;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    egp_decode u_decode (
        .word          (req_word),
        .state         (state_reg),
        .max_ref_index (max_ref_reg),
        .state_next    (dec_state),
        .res_valid     (res_valid),
        .res_word      (res_word)
    );

    assign state_next = accept ? dec_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, pending_mask: 4'd0, current_part: 2'd0,
                           zero_count: 5'd0, suffix_left: 5'd0, value_accum: 5'd0,
                           value_too_big: 1'b0};
            max_ref_reg <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                max_ref_reg <= cfg_data;
        end
    end

    egp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (accept && res_valid),
        .push_word  (res_word),
        .full       (buf_full),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word)
    );

`ifndef NO_ASSERTIONS
    // Outside a macroblock no partition may be left waiting.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> state_reg.pending_mask == 4'd0)
        else $error("partitions pending while idle");

    // The partition being parsed is always one that still needs an index.
    a_current_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_IDLE
            |-> state_reg.pending_mask[state_reg.current_part])
        else $error("current partition not pending");

    // A suffix in progress always has at least one bit left to read.
    a_suffix_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_SUFFIX |-> state_reg.suffix_left != 5'd0)
        else $error("suffix phase with no bits left");

    // A start word never leaves a result-less macroblock idle.
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_word.operation == OP_START && !res_valid
            |=> state_reg.phase == PH_PREFIX)
        else $error("start without result did not begin parsing");
`endif

endmodule
